@@ hw/rtl/ptrc_pkg.sv @@
`timescale 1ns / 1ps

package ptrc_pkg;

   localparam int NUM_TYPES = 32;

   localparam int OP_W    = 2;
   localparam int TYPE_W  = 5;
   localparam int FRAME_W = 32;
   localparam int PAY_W   = 8;
   localparam int SPC_W   = 16;

   // event_type is 5 bits wide, so slots beyond 32 can never be addressed
   localparam int NUM_SLOTS = (NUM_TYPES > (1 << TYPE_W)) ? (1 << TYPE_W) : NUM_TYPES;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   localparam logic [SLOT_W-1:0] LAST_SLOT     = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [SPC_W-1:0]  SPACING_RESET = SPC_W'(1);

   typedef enum logic [OP_W-1:0] {
      OP_DETECT  = 2'd0,
      OP_FLUSH   = 2'd1,
      OP_SPACING = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_UPDATE = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_DRAIN  = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;       // capture detection, table read already issued
      logic spc_wr;     // write spacing entry from request ports
      logic update;     // evaluate and update the run of the captured type
      logic scan_init;  // restart flush scan at slot 0
      logic scan;       // issue scan read and advance
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_last;
   } dp_sts_type;

endpackage

@@ hw/rtl/ptrc_ctrl.sv @@
`timescale 1ns / 1ps

module ptrc_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ptrc_pkg::OP_W-1:0]    req_operation,
   input  logic [ptrc_pkg::TYPE_W-1:0]  req_event_type,
   input  ptrc_pkg::dp_sts_type         sts,
   output ptrc_pkg::ctl_cmd_type        cmd,
   output logic                         busy
);

   ptrc_pkg::state_type state_ff;
   ptrc_pkg::state_type state_in;
   logic                type_ok;

   assign type_ok = int'(req_event_type) < ptrc_pkg::NUM_TYPES;
   assign busy    = state_ff != ptrc_pkg::ST_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ptrc_pkg::ST_IDLE: begin
            if (start) begin
               case (req_operation)
                  ptrc_pkg::OP_DETECT: begin
                     if (type_ok) begin
                        cmd.load = 1'b1;
                        state_in = ptrc_pkg::ST_UPDATE;
                     end
                  end
                  ptrc_pkg::OP_FLUSH: begin
                     cmd.scan_init = 1'b1;
                     state_in      = ptrc_pkg::ST_SCAN;
                  end
                  ptrc_pkg::OP_SPACING: begin
                     cmd.spc_wr = type_ok;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ptrc_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ptrc_pkg::ST_IDLE;
         end
         ptrc_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = ptrc_pkg::ST_DRAIN;
            end
         end
         ptrc_pkg::ST_DRAIN: begin
            state_in = ptrc_pkg::ST_IDLE;
         end
         default: begin
            state_in = ptrc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptrc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/ptrc_datapath.sv @@
`timescale 1ns / 1ps

module ptrc_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  ptrc_pkg::ctl_cmd_type         cmd,
   output ptrc_pkg::dp_sts_type          sts,
   input  logic [ptrc_pkg::TYPE_W-1:0]   req_event_type,
   input  logic [ptrc_pkg::FRAME_W-1:0]  req_frame_number,
   input  logic [ptrc_pkg::PAY_W-1:0]    req_payload,
   input  logic [ptrc_pkg::SPC_W-1:0]    req_spacing_value,
   output logic                          rsp_valid,
   output logic [ptrc_pkg::TYPE_W-1:0]   rsp_run_type,
   output logic [ptrc_pkg::PAY_W-1:0]    rsp_run_payload,
   output logic [ptrc_pkg::FRAME_W-1:0]  rsp_first_frame,
   output logic [ptrc_pkg::FRAME_W-1:0]  rsp_end_frame,
   output logic                          rsp_last
);

   // run tables
   logic [ptrc_pkg::FRAME_W-1:0] start_mem [ptrc_pkg::NUM_SLOTS];
   logic [ptrc_pkg::FRAME_W-1:0] end_mem   [ptrc_pkg::NUM_SLOTS];
   logic [ptrc_pkg::PAY_W-1:0]   data_mem  [ptrc_pkg::NUM_SLOTS];
   logic [ptrc_pkg::SPC_W-1:0]   spc_mem   [ptrc_pkg::NUM_SLOTS];

   logic [ptrc_pkg::NUM_SLOTS-1:0] run_open_ff;
   logic [ptrc_pkg::NUM_SLOTS-1:0] spc_valid_ff;

   logic [ptrc_pkg::FRAME_W-1:0] start_rd_ff;
   logic [ptrc_pkg::FRAME_W-1:0] end_rd_ff;
   logic [ptrc_pkg::PAY_W-1:0]   data_rd_ff;
   logic [ptrc_pkg::SPC_W-1:0]   spc_rd_ff;

   logic [ptrc_pkg::SLOT_W-1:0]  slot_ff;
   logic [ptrc_pkg::FRAME_W-1:0] frame_ff;
   logic [ptrc_pkg::PAY_W-1:0]   pay_ff;

   logic [ptrc_pkg::SLOT_W-1:0]  idx_ff;
   logic [ptrc_pkg::SLOT_W-1:0]  idx_in;
   logic [ptrc_pkg::SLOT_W-1:0]  pend_idx_ff;
   logic                         pend_ff;

   logic                         rsp_valid_ff;
   logic [ptrc_pkg::TYPE_W-1:0]  rsp_type_ff;
   logic [ptrc_pkg::PAY_W-1:0]   rsp_payload_ff;
   logic [ptrc_pkg::FRAME_W-1:0] rsp_start_ff;
   logic [ptrc_pkg::FRAME_W-1:0] rsp_end_ff;
   logic                         rsp_last_ff;

   logic [ptrc_pkg::SLOT_W-1:0]  req_slot;
   logic [ptrc_pkg::SLOT_W-1:0]  rd_addr;
   logic [ptrc_pkg::SPC_W-1:0]   spc_eff;
   logic [ptrc_pkg::FRAME_W:0]   reach;
   logic                         cur_open;
   logic                         do_close;
   logic                         det_emit;
   logic                         scan_emit;
   logic                         open_above;
   logic                         new_run;
   logic                         extend_end;
   logic [ptrc_pkg::TYPE_W-1:0]  slot_type;
   logic [ptrc_pkg::TYPE_W-1:0]  pend_type;

   assign req_slot = req_event_type[ptrc_pkg::SLOT_W-1:0];
   assign rd_addr  = cmd.scan ? idx_ff : req_slot;
   assign sts.scan_last = idx_ff == ptrc_pkg::LAST_SLOT;
   assign idx_in   = cmd.scan_init ? '0 : (cmd.scan ? idx_ff + 1'b1 : idx_ff);

   assign cur_open = run_open_ff[slot_ff];
   assign spc_eff  = spc_valid_ff[slot_ff] ? spc_rd_ff : ptrc_pkg::SPACING_RESET;
   assign reach    = {1'b0, end_rd_ff} + {{(ptrc_pkg::FRAME_W + 1 - ptrc_pkg::SPC_W){1'b0}}, spc_eff};
   assign do_close = (reach <= {1'b0, frame_ff}) || (data_rd_ff != pay_ff);

   assign det_emit   = cmd.update && cur_open && do_close;
   assign new_run    = cmd.update && (!cur_open || do_close);
   assign extend_end = cmd.update && cur_open && !do_close && (frame_ff > end_rd_ff);
   assign scan_emit  = pend_ff && run_open_ff[pend_idx_ff];

   always_comb begin
      open_above = 1'b0;
      for (int i = 0; i < ptrc_pkg::NUM_SLOTS; i++) begin
         if (run_open_ff[i] && (i > int'(pend_idx_ff))) begin
            open_above = 1'b1;
         end
      end
   end

   always_comb begin
      slot_type = '0;
      pend_type = '0;
      slot_type[ptrc_pkg::SLOT_W-1:0] = slot_ff;
      pend_type[ptrc_pkg::SLOT_W-1:0] = pend_idx_ff;
   end

   // table memories: registered read, one write port each
   always_ff @(posedge clock) begin
      start_rd_ff <= start_mem[rd_addr];
      end_rd_ff   <= end_mem[rd_addr];
      data_rd_ff  <= data_mem[rd_addr];
      spc_rd_ff   <= spc_mem[rd_addr];
      if (new_run) begin
         start_mem[slot_ff] <= frame_ff;
         data_mem[slot_ff]  <= pay_ff;
      end
      if (new_run || extend_end) begin
         end_mem[slot_ff] <= frame_ff;
      end
      if (cmd.spc_wr) begin
         spc_mem[req_slot] <= req_spacing_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         slot_ff  <= req_slot;
         frame_ff <= req_frame_number;
         pay_ff   <= req_payload;
      end
      pend_idx_ff    <= idx_ff;
      idx_ff         <= idx_in;
      rsp_type_ff    <= det_emit ? slot_type : pend_type;
      rsp_payload_ff <= data_rd_ff;
      rsp_start_ff   <= start_rd_ff;
      rsp_end_ff     <= end_rd_ff;
      rsp_last_ff    <= det_emit || !open_above;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff  <= '0;
         spc_valid_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= cmd.scan;
         rsp_valid_ff <= det_emit || scan_emit;
         if (cmd.update) begin
            run_open_ff[slot_ff] <= 1'b1;
         end
         if (scan_emit) begin
            run_open_ff[pend_idx_ff] <= 1'b0;
         end
         if (cmd.spc_wr) begin
            spc_valid_ff[req_slot] <= 1'b1;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_run_type    = rsp_type_ff;
   assign rsp_run_payload = rsp_payload_ff;
   assign rsp_first_frame = rsp_start_ff;
   assign rsp_end_frame   = rsp_end_ff;
   assign rsp_last        = rsp_last_ff;

   a_emit_excl: assert property (@(posedge clock) disable iff (reset)
      !(det_emit && scan_emit))
      else $error("detection and flush results collide");

   a_update_opens: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> run_open_ff[$past(slot_ff)])
      else $error("run not open after detection update");

   a_scan_closes: assert property (@(posedge clock) disable iff (reset)
      scan_emit |=> !run_open_ff[$past(pend_idx_ff)])
      else $error("flushed run still open");

   a_det_last: assert property (@(posedge clock) disable iff (reset)
      det_emit |=> rsp_valid_ff && rsp_last_ff)
      else $error("detection result not marked last");

endmodule

@@ hw/rtl/per_type_event_run_coalescer_top.sv @@
`timescale 1ns / 1ps
// Channel   Ports                                   Handshake
// request   req_operation .. req_spacing_value      taken when start && !busy
// response  rsp_run_type .. rsp_last                one cycle, marked by rsp_valid
//
// Detection: table read in the accept cycle, update the next; a closed run appears on
//   rsp_* in the cycle after the update.
// Set spacing: written in the accept cycle. Unused operation or out-of-range type: dropped.
// Flush: one slot scanned per cycle through the table read
//   port; results trail the scan through the read and rsp_* registers, the last one flagged.
// Reset is synchronous: all runs closed, all spacings read as 1.
// The receiver cannot stall; every strobed result is a completed transaction.

module per_type_event_run_coalescer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ptrc_pkg::OP_W-1:0]     req_operation,
   input  logic [ptrc_pkg::TYPE_W-1:0]   req_event_type,
   input  logic [ptrc_pkg::FRAME_W-1:0]  req_frame_number,
   input  logic [ptrc_pkg::PAY_W-1:0]    req_payload,
   input  logic [ptrc_pkg::SPC_W-1:0]    req_spacing_value,
   output logic                          rsp_valid,
   output logic [ptrc_pkg::TYPE_W-1:0]   rsp_run_type,
   output logic [ptrc_pkg::PAY_W-1:0]    rsp_run_payload,
   output logic [ptrc_pkg::FRAME_W-1:0]  rsp_first_frame,
   output logic [ptrc_pkg::FRAME_W-1:0]  rsp_end_frame,
   output logic                          rsp_last
);

   ptrc_pkg::ctl_cmd_type cmd;
   ptrc_pkg::dp_sts_type  sts;

   ptrc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_operation  (req_operation),
      .req_event_type (req_event_type),
      .sts            (sts),
      .cmd            (cmd),
      .busy           (busy)
   );

   ptrc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_event_type    (req_event_type),
      .req_frame_number  (req_frame_number),
      .req_payload       (req_payload),
      .req_spacing_value (req_spacing_value),
      .rsp_valid         (rsp_valid),
      .rsp_run_type      (rsp_run_type),
      .rsp_run_payload   (rsp_run_payload),
      .rsp_first_frame   (rsp_first_frame),
      .rsp_end_frame     (rsp_end_frame),
      .rsp_last          (rsp_last)
   );

endmodule

@@ test/per_type_event_run_coalescer_top_tb.sv @@
`timescale 1ns / 1ps

module per_type_event_run_coalescer_top_tb;

   localparam logic [ptrc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int TAIL_CYCLES = ptrc_pkg::NUM_TYPES + 8;

   typedef struct packed {
      logic [ptrc_pkg::OP_W-1:0]    op;
      logic [ptrc_pkg::TYPE_W-1:0]  etype;
      logic [ptrc_pkg::FRAME_W-1:0] frame;
      logic [ptrc_pkg::PAY_W-1:0]   pay;
      logic [ptrc_pkg::SPC_W-1:0]   spc;
   } req_item_type;

   typedef struct packed {
      logic [ptrc_pkg::TYPE_W-1:0]  run_type;
      logic [ptrc_pkg::PAY_W-1:0]   run_payload;
      logic [ptrc_pkg::FRAME_W-1:0] first_frame;
      logic [ptrc_pkg::FRAME_W-1:0] end_frame;
      logic                         last;
   } run_item_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [ptrc_pkg::OP_W-1:0]     req_operation = '0;
   logic [ptrc_pkg::TYPE_W-1:0]   req_event_type = '0;
   logic [ptrc_pkg::FRAME_W-1:0]  req_frame_number = '0;
   logic [ptrc_pkg::PAY_W-1:0]    req_payload = '0;
   logic [ptrc_pkg::SPC_W-1:0]    req_spacing_value = '0;
   logic                          rsp_valid;
   logic [ptrc_pkg::TYPE_W-1:0]   rsp_run_type;
   logic [ptrc_pkg::PAY_W-1:0]    rsp_run_payload;
   logic [ptrc_pkg::FRAME_W-1:0]  rsp_first_frame;
   logic [ptrc_pkg::FRAME_W-1:0]  rsp_end_frame;
   logic                          rsp_last;

   req_item_type pending_reqs[$];
   run_item_type expected_runs[$];
   req_item_type held_req;
   int           sender_idle_pct = 0;
   int           errors = 0;

   // predictor state, one slot per event type
   logic                         slot_open [ptrc_pkg::NUM_TYPES];
   logic [ptrc_pkg::FRAME_W-1:0] slot_start[ptrc_pkg::NUM_TYPES];
   logic [ptrc_pkg::FRAME_W-1:0] slot_end  [ptrc_pkg::NUM_TYPES];
   logic [ptrc_pkg::PAY_W-1:0]   slot_pay  [ptrc_pkg::NUM_TYPES];
   logic [ptrc_pkg::SPC_W-1:0]   slot_spc  [ptrc_pkg::NUM_TYPES];

   per_type_event_run_coalescer_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_event_type(req_event_type),
      .req_frame_number(req_frame_number), .req_payload(req_payload),
      .req_spacing_value(req_spacing_value),
      .rsp_valid(rsp_valid), .rsp_run_type(rsp_run_type),
      .rsp_run_payload(rsp_run_payload), .rsp_first_frame(rsp_first_frame),
      .rsp_end_frame(rsp_end_frame), .rsp_last(rsp_last)
   );

   always #6 clock = ~clock;

   function automatic run_item_type close_run(int t, logic is_last);
      run_item_type r;
      r.run_type    = t[ptrc_pkg::TYPE_W-1:0];
      r.run_payload = slot_pay[t];
      r.first_frame = slot_start[t];
      r.end_frame   = slot_end[t];
      r.last        = is_last;
      return r;
   endfunction

   task automatic coalesce_step(input req_item_type r);
      int          t;
      int          n;
      logic [32:0] reach;
      t = int'(r.etype);
      n = 0;
      if (r.op == ptrc_pkg::OP_FLUSH) begin
         for (int i = 0; i < ptrc_pkg::NUM_TYPES; i++) begin
            if (slot_open[i] && n < 32) begin
               expected_runs.insert(expected_runs.size(), close_run(i, 1'b0));
               slot_open[i] = 1'b0;
               n++;
            end
         end
         if (n > 0) expected_runs[$].last = 1'b1;
      end else if (t < ptrc_pkg::NUM_TYPES) begin
         if (r.op == ptrc_pkg::OP_SPACING) begin
            slot_spc[t] = r.spc;
         end else if (r.op == ptrc_pkg::OP_DETECT) begin
            if (!slot_open[t]) begin
               slot_open[t]  = 1'b1;
               slot_start[t] = r.frame;
               slot_end[t]   = r.frame;
               slot_pay[t]   = r.pay;
            end else begin
               reach = {1'b0, slot_end[t]} + {17'b0, slot_spc[t]};
               if (reach <= {1'b0, r.frame} || slot_pay[t] != r.pay) begin
                  expected_runs.insert(expected_runs.size(), close_run(t, 1'b1));
                  slot_start[t] = r.frame;
                  slot_end[t]   = r.frame;
                  slot_pay[t]   = r.pay;
               end else if (r.frame > slot_end[t]) begin
                  slot_end[t] = r.frame;
               end
            end
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      req_item_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) coalesce_step(held_req);
         if (!start || !busy) begin
            if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
               nxt = pending_reqs.pop_front();
               held_req = nxt;
               req_operation     <= nxt.op;
               req_event_type    <= nxt.etype;
               req_frame_number  <= nxt.frame;
               req_payload       <= nxt.pay;
               req_spacing_value <= nxt.spc;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      run_item_type exp_run;
      if (!reset && rsp_valid) begin
         if (expected_runs.size() == 0) begin
            $error("unexpected run: type %0d payload %0h first %0h end %0h",
                   rsp_run_type, rsp_run_payload, rsp_first_frame, rsp_end_frame);
            errors++;
         end else begin
            exp_run = expected_runs.pop_front();
            if (rsp_run_type !== exp_run.run_type) begin
               $error("run_type: expected %0d, got %0d", exp_run.run_type, rsp_run_type);
               errors++;
            end
            if (rsp_run_payload !== exp_run.run_payload) begin
               $error("run_payload: expected %0h, got %0h",
                      exp_run.run_payload, rsp_run_payload);
               errors++;
            end
            if (rsp_first_frame !== exp_run.first_frame) begin
               $error("first_frame: expected %0h, got %0h",
                      exp_run.first_frame, rsp_first_frame);
               errors++;
            end
            if (rsp_end_frame !== exp_run.end_frame) begin
               $error("end_frame: expected %0h, got %0h", exp_run.end_frame, rsp_end_frame);
               errors++;
            end
            if (rsp_last !== exp_run.last) begin
               $error("last: expected %0b, got %0b", exp_run.last, rsp_last);
               errors++;
            end
         end
      end
   end

   task automatic push_req(input logic [ptrc_pkg::OP_W-1:0] op, input int t,
                           input logic [31:0] f, input int p, input int s);
      req_item_type r;
      r.op    = op;
      r.etype = t[ptrc_pkg::TYPE_W-1:0];
      r.frame = f;
      r.pay   = p[ptrc_pkg::PAY_W-1:0];
      r.spc   = s[ptrc_pkg::SPC_W-1:0];
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   task automatic gen_random(input int count, input logic [31:0] base);
      logic [31:0] frame;
      int          sel;
      int          t;
      int          p;
      int          s;
      frame = base;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(99, 0);
         if (sel < 70) frame = frame + $urandom_range(3, 0);
         else if (sel < 85) frame = frame + $urandom_range(70000, 4);
         else if (sel < 90) frame = frame - $urandom_range(5, 1);
         else if (sel < 95) frame = $urandom;
         t = ($urandom_range(9, 0) < 6) ? $urandom_range(3, 0) : $urandom_range(31, 0);
         p = ($urandom_range(3, 0) == 0) ? $urandom_range(255, 0) : $urandom_range(1, 0);
         s = ($urandom_range(3, 0) == 0) ? $urandom_range(65535, 0) : $urandom_range(10, 0);
         sel = $urandom_range(99, 0);
         if (k == count / 2) begin
            // open every type, then drain them all at once
            for (int i = 0; i < ptrc_pkg::NUM_TYPES; i++)
               push_req(ptrc_pkg::OP_DETECT, i, frame, $urandom_range(255, 0), s);
            push_req(ptrc_pkg::OP_FLUSH, t, frame, p, s);
         end else if (sel < 75) begin
            push_req(ptrc_pkg::OP_DETECT, t, frame, p, s);
         end else if (sel < 83) begin
            push_req(ptrc_pkg::OP_FLUSH, t, $urandom, p, s);
         end else if (sel < 95) begin
            push_req(ptrc_pkg::OP_SPACING, t, $urandom, p, s);
         end else begin
            push_req(OP_UNUSED, t, $urandom, p, s);
         end
      end
   endtask

   task automatic wait_drained;
      do @(posedge clock);
      while (pending_reqs.size() != 0 || start || expected_runs.size() != 0);
   endtask

   initial begin
      for (int i = 0; i < ptrc_pkg::NUM_TYPES; i++) begin
         slot_open[i] = 1'b0;
         slot_spc[i]  = ptrc_pkg::SPACING_RESET;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed
      push_req(ptrc_pkg::OP_FLUSH, 0, 0, 0, 0);
      push_req(OP_UNUSED, 31, 32'hFFFF_FFFF, 255, 16'hFFFF);
      push_req(ptrc_pkg::OP_SPACING, 0, 0, 0, 0);
      push_req(ptrc_pkg::OP_SPACING, 31, 0, 0, 16'hFFFF);
      push_req(ptrc_pkg::OP_DETECT, 0, 0, 0, 0);
      push_req(ptrc_pkg::OP_DETECT, 0, 0, 0, 0);
      push_req(ptrc_pkg::OP_DETECT, 31, 32'hFFFF_FF00, 255, 0);
      push_req(ptrc_pkg::OP_DETECT, 31, 32'hFFFF_FFFF, 255, 0);
      push_req(ptrc_pkg::OP_DETECT, 31, 32'hFFFF_FFFF, 254, 0);
      push_req(ptrc_pkg::OP_DETECT, 5, 100, 8'h55, 0);
      push_req(ptrc_pkg::OP_DETECT, 5, 100, 8'h55, 0);
      push_req(ptrc_pkg::OP_DETECT, 5, 99, 8'h55, 0);
      push_req(ptrc_pkg::OP_DETECT, 5, 101, 8'h55, 0);
      push_req(ptrc_pkg::OP_SPACING, 5, 0, 0, 3);
      push_req(ptrc_pkg::OP_DETECT, 5, 103, 8'h55, 0);
      push_req(ptrc_pkg::OP_DETECT, 5, 106, 8'h55, 0);
      push_req(ptrc_pkg::OP_DETECT, 10, 200, 8'hAA, 0);
      push_req(ptrc_pkg::OP_FLUSH, 0, 0, 0, 0);
      push_req(ptrc_pkg::OP_FLUSH, 0, 0, 0, 0);
      sender_idle_pct = 15;
      wait_drained();

      gen_random(55, 32'd1000);
      wait_drained();
      sender_idle_pct = 81;
      gen_random(55, 32'hFFFF_FE00);
      wait_drained();
      sender_idle_pct = 0;
      gen_random(55, $urandom);
      push_req(ptrc_pkg::OP_FLUSH, 0, 0, 0, 0);

      while (pending_reqs.size() != 0 || start) @(posedge clock);
      for (int c = 0; c < 4000 && expected_runs.size() != 0; c++) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_runs.size() != 0) begin
         $error("%0d expected runs never arrived", expected_runs.size());
         errors++;
      end
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
